/* hdl/rlpe_pkg.sv */
// shared types and constants for the rgb lamp pwm slot encoder
// no dependencies; imported by every module of the block
package rlpe_pkg;

  localparam int LAMP_SLOTS     = 24;
  localparam int LAMP_IDX_W     = $clog2(LAMP_SLOTS);
  localparam int MAX_SLOTS      = 64;
  localparam int RESET_SLOTS_DEF = 50;
  localparam int DUTY_W         = 16;
  localparam int CHAN_W         = 8;
  localparam int CFG_ADDR_W     = 4;
  localparam int CFG_DATA_W     = 32;

  localparam logic CMD_LAMP = 1'b0;
  localparam logic CMD_EOF  = 1'b1;

  localparam logic ORDER_GRB = 1'b0;
  localparam logic ORDER_RGB = 1'b1;

  typedef enum logic [1:0] {
    REG_BRIGHTNESS = 2'd0,
    REG_BYTE_ORDER = 2'd1,
    REG_ONE_DUTY   = 2'd2,
    REG_ZERO_DUTY  = 2'd3
  } cfg_addr_t;

  typedef struct packed {
    logic              byte_order;
    logic [CHAN_W-1:0] brightness;
  } scale_cfg_t;

  typedef struct packed {
    logic                  load;
    logic                  eof;
    logic [LAMP_SLOTS-1:0] bits;
  } load_t;

  typedef struct packed {
    logic valid;
    logic eof;
    logic one_bit;
    logic last;
  } cell_t;

endpackage

/* hdl/rlpe_cell.sv */
// one slot cell of the shift row: holds one duty slot and passes it on
// depends on rlpe_pkg
module rlpe_cell
  import rlpe_pkg::*;
#(
  parameter int IDX         = 0,
  parameter int RESET_SLOTS = RESET_SLOTS_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  load_t ld,
  input  logic  shift,
  input  cell_t nbr,
  output cell_t q
);

  localparam logic                  IN_LAMP = (IDX < LAMP_SLOTS);
  localparam logic [LAMP_IDX_W-1:0] BIT_SEL =
    IN_LAMP ? LAMP_IDX_W'(LAMP_SLOTS - 1 - IDX) : '0;

  cell_t q_r;
  cell_t q_nxt;
  cell_t load_val;

  always_comb begin
    if (ld.eof) begin
      load_val.valid   = (IDX < RESET_SLOTS);
      load_val.eof     = 1'b1;
      load_val.one_bit = 1'b0;
      load_val.last    = (IDX == RESET_SLOTS - 1);
    end else begin
      load_val.valid   = IN_LAMP;
      load_val.eof     = 1'b0;
      load_val.one_bit = IN_LAMP & ld.bits[BIT_SEL];
      load_val.last    = (IDX == LAMP_SLOTS - 1);
    end
  end

  always_comb begin
    priority if (ld.load) begin
      q_nxt = load_val;
    end else if (shift) begin
      q_nxt = nbr;
    end else begin
      q_nxt = q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else begin
      q_r.valid <= q_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    q_r.eof     <= q_nxt.eof;
    q_r.one_bit <= q_nxt.one_bit;
    q_r.last    <= q_nxt.last;
  end

  assign q = q_r;

endmodule

/* hdl/rlpe_loader.sv */
// input holding register and brightness scaling; builds the 24 slot bit pattern
// depends on rlpe_pkg
module rlpe_loader
  import rlpe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic              cmd,
  input  logic [CHAN_W-1:0] red,
  input  logic [CHAN_W-1:0] green,
  input  logic [CHAN_W-1:0] blue,
  input  scale_cfg_t        cfg,
  input  logic              row_free,
  output logic              hold_free,
  output load_t             ld
);

  logic              hold_valid_r;
  logic              hold_valid_nxt;
  logic              cmd_r;
  logic [CHAN_W-1:0] red_r;
  logic [CHAN_W-1:0] green_r;
  logic [CHAN_W-1:0] blue_r;
  logic              take;
  logic [CHAN_W-1:0] s_red;
  logic [CHAN_W-1:0] s_green;
  logic [CHAN_W-1:0] s_blue;

  // v*b/255 as (p + p/256 + 1) / 256, exact over the 8x8 product range
  function automatic logic [CHAN_W-1:0] scale(input logic [CHAN_W-1:0] v,
                                              input logic [CHAN_W-1:0] b);
    logic [2*CHAN_W-1:0] p;
    logic [2*CHAN_W:0]   s;
    p = v * b;
    s = {1'b0, p} + {{(CHAN_W+1){1'b0}}, p[2*CHAN_W-1:CHAN_W]} + 1'b1;
    return s[2*CHAN_W-1:CHAN_W];
  endfunction

  assign take      = hold_valid_r & row_free;
  assign hold_free = ~hold_valid_r | take;

  always_comb begin
    priority if (in_fire) begin
      hold_valid_nxt = 1'b1;
    end else if (take) begin
      hold_valid_nxt = 1'b0;
    end else begin
      hold_valid_nxt = hold_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r   <= cmd;
      red_r   <= red;
      green_r <= green;
      blue_r  <= blue;
    end
  end

  assign s_red   = scale(red_r, cfg.brightness);
  assign s_green = scale(green_r, cfg.brightness);
  assign s_blue  = scale(blue_r, cfg.brightness);

  always_comb begin
    ld.load = take;
    ld.eof  = (cmd_r == CMD_EOF);
    if (cfg.byte_order == ORDER_RGB) begin
      ld.bits = {s_red, s_green, s_blue};
    end else begin
      ld.bits = {s_green, s_red, s_blue};
    end
  end

endmodule

/* hdl/rgb_led_pwm_slot_encoder.sv */
// Turns lamp colour requests into a stream of PWM duty slots, one slot per
// cycle at the output while out_tready is high. A lamp request (tuser 0)
// gives 24 slots, most significant bit first, green-red-blue or red-green-blue
// as byte_order sets, each channel scaled by brightness/255; an end-of-frame
// request (tuser 1) gives RESET_SLOT_COUNT zero slots (at most 64). tlast
// marks the final slot of each request. Slots sit in a row of cells that
// shift towards the output head once per taken slot; the row is loaded in
// parallel from a one-deep holding register in the cycle its last slot
// leaves, so with the output always ready requests go out back to back with
// no gap. A taken request passes the holding register, then is loaded into
// the row with its first slot at the head. Registers at 0x0 brightness, 0x4
// byte_order, 0x8 one_duty, 0xC zero_duty; change them only while idle.
module rgb_led_pwm_slot_encoder
  import rlpe_pkg::*;
#(
  parameter int RESET_SLOT_COUNT = RESET_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [23:0]           in_tdata,   // red [7:0], green [15:8], blue [23:16]
  input  logic                  in_tuser,   // command
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [DUTY_W-1:0]     out_tdata,  // duty [15:0]
  output logic                  out_tlast,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int RST_SLOTS = (RESET_SLOT_COUNT > MAX_SLOTS) ? MAX_SLOTS : RESET_SLOT_COUNT;
  localparam int ROW_LEN   = (RST_SLOTS > LAMP_SLOTS) ? RST_SLOTS : LAMP_SLOTS;

  logic [CHAN_W-1:0] brightness_r;
  logic              byte_order_r;
  logic [DUTY_W-1:0] one_duty_r;
  logic [DUTY_W-1:0] zero_duty_r;
  cfg_addr_t         addr;
  logic              cfg_wr;
  scale_cfg_t        scfg;
  logic              in_fire;
  logic              out_fire;
  logic              row_free;
  logic              hold_free;
  load_t             ld;
  cell_t             row [ROW_LEN];

  // configuration port
  assign cfg_pready = 1'b1;
  assign addr       = cfg_addr_t'(cfg_paddr[CFG_ADDR_W-1:2]);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r <= '1;
      byte_order_r <= ORDER_GRB;
      one_duty_r   <= '0;
      zero_duty_r  <= '0;
    end else if (cfg_wr) begin
      unique case (addr)
        REG_BRIGHTNESS: brightness_r <= cfg_pwdata[CHAN_W-1:0];
        REG_BYTE_ORDER: byte_order_r <= cfg_pwdata[0];
        REG_ONE_DUTY:   one_duty_r   <= cfg_pwdata[DUTY_W-1:0];
        REG_ZERO_DUTY:  zero_duty_r  <= cfg_pwdata[DUTY_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (addr)
      REG_BRIGHTNESS: cfg_prdata = {{(CFG_DATA_W-CHAN_W){1'b0}}, brightness_r};
      REG_BYTE_ORDER: cfg_prdata = {{(CFG_DATA_W-1){1'b0}}, byte_order_r};
      REG_ONE_DUTY:   cfg_prdata = {{(CFG_DATA_W-DUTY_W){1'b0}}, one_duty_r};
      REG_ZERO_DUTY:  cfg_prdata = {{(CFG_DATA_W-DUTY_W){1'b0}}, zero_duty_r};
    endcase
  end

  assign scfg.brightness = brightness_r;
  assign scfg.byte_order = byte_order_r;

  // handshakes
  assign in_tready = hold_free;
  assign in_fire   = in_tvalid & in_tready;
  assign out_fire  = out_tvalid & out_tready;
  assign row_free  = ~row[1].valid & (~row[0].valid | out_fire);

  rlpe_loader u_loader (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .cmd       (in_tuser),
    .red       (in_tdata[7:0]),
    .green     (in_tdata[15:8]),
    .blue      (in_tdata[23:16]),
    .cfg       (scfg),
    .row_free  (row_free),
    .hold_free (hold_free),
    .ld        (ld)
  );

  for (genvar g = 0; g < ROW_LEN; g++) begin : g_row
    cell_t nbr;
    if (g == ROW_LEN - 1) begin : g_tail
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = row[g+1];
    end
    rlpe_cell #(
      .IDX         (g),
      .RESET_SLOTS (RST_SLOTS)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ld    (ld),
      .shift (out_fire),
      .nbr   (nbr),
      .q     (row[g])
    );
  end

  // output head
  assign out_tvalid = row[0].valid;
  assign out_tlast  = row[0].last;
  always_comb begin
    priority if (row[0].eof) begin
      out_tdata = '0;
    end else if (row[0].one_bit) begin
      out_tdata = one_duty_r;
    end else begin
      out_tdata = zero_duty_r;
    end
  end

`ifndef SYNTH
  a_row_packed: assert property (@(posedge clk) disable iff (!rst_n)
    row[1].valid |-> row[0].valid)
    else $error("slot row has a gap at its head");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    ld.load |-> (!row[1].valid && (!row[0].valid || out_fire)))
    else $error("row loaded while slots still pending");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    ld.load |=> out_tvalid)
    else $error("loaded request gave no slot at the head");

  a_last_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> !row[1].valid)
    else $error("slots queued behind the final slot of a request");
`endif

endmodule

/* tb/rgb_led_pwm_slot_encoder_tb.sv */
`timescale 1ns / 1ps
// self-checking testbench for rgb_led_pwm_slot_encoder: predicts every duty slot
// from the register settings and checks the slot stream; needs rlpe_pkg and the block
module rgb_led_pwm_slot_encoder_tb;
  import rlpe_pkg::*;

  localparam int EOF_SLOTS = (RESET_SLOTS_DEF > MAX_SLOTS) ? MAX_SLOTS : RESET_SLOTS_DEF;
  localparam int HOLD_AT = 150;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_PRINTS = 40;

  typedef struct packed {
    logic        cmd;
    logic [23:0] rgb;
  } lamp_req_t;

  typedef struct {
    logic [DUTY_W-1:0] duty;
    logic              last;
  } slot_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [23:0]           in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [DUTY_W-1:0]     out_tdata;
  logic                  out_tlast;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  lamp_req_t   lamp_q[$];
  slot_t       slot_q[$];
  int          req_cnt = 0;
  int          mismatch_cnt = 0;
  int          hold_left = 0;
  bit          hold_done = 0;
  bit          steady = 0;

  logic [CHAN_W-1:0] bright_cfg = 8'd255;
  logic              order_cfg = ORDER_GRB;
  logic [DUTY_W-1:0] one_cfg = '0;
  logic [DUTY_W-1:0] zero_cfg = '0;

  rgb_led_pwm_slot_encoder #(
    .RESET_SLOT_COUNT(RESET_SLOTS_DEF)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  task automatic flag_mismatch(string msg);
    if (mismatch_cnt < MAX_PRINTS) $display("mismatch @%0t: %s", $time, msg);
    mismatch_cnt++;
  endtask

  function automatic logic [CHAN_W-1:0] scaled_level(logic [CHAN_W-1:0] v);
    logic [15:0] prod;
    prod = v * bright_cfg;
    return CHAN_W'(prod / 16'd255);
  endfunction

  // duty slots that one accepted request should give
  function automatic void expand_request(logic cmd, logic [23:0] rgb);
    logic [CHAN_W-1:0] seq [3];
    slot_t s;
    if (cmd == CMD_EOF) begin
      for (int k = 0; k < EOF_SLOTS; k++) begin
        s.duty = '0;
        s.last = (k == EOF_SLOTS - 1);
        slot_q.push_back(s);
      end
    end else begin
      seq[0] = scaled_level((order_cfg == ORDER_RGB) ? rgb[7:0] : rgb[15:8]);
      seq[1] = scaled_level((order_cfg == ORDER_RGB) ? rgb[15:8] : rgb[7:0]);
      seq[2] = scaled_level(rgb[23:16]);
      for (int n = 0; n < 3; n++) begin
        for (int b = CHAN_W - 1; b >= 0; b--) begin
          s.duty = seq[n][b] ? one_cfg : zero_cfg;
          s.last = (n == 2) && (b == 0);
          slot_q.push_back(s);
        end
      end
    end
  endfunction

  // driver
  always @(posedge clk) begin
    lamp_req_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expand_request(in_tuser, in_tdata);
        req_cnt <= req_cnt + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (lamp_q.size() != 0 && (steady || $urandom_range(99) >= 29)) begin
          nxt = lamp_q.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= nxt.cmd;
          in_tdata <= nxt.rgb;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and output back-pressure
  always @(posedge clk) begin
    slot_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (slot_q.size() == 0) begin
          flag_mismatch($sformatf("slot duty %h last %b with nothing expected",
                                  out_tdata, out_tlast));
        end else begin
          e = slot_q.pop_front();
          if (out_tdata !== e.duty)
            flag_mismatch($sformatf("duty %h, expected %h", out_tdata, e.duty));
          if (out_tlast !== e.last)
            flag_mismatch($sformatf("last %b, expected %b", out_tlast, e.last));
        end
      end
      if (!hold_done && req_cnt == HOLD_AT) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= steady || ($urandom_range(99) >= 29);
      end
    end
  end

  task automatic set_reg(cfg_addr_t idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_BRIGHTNESS: bright_cfg = data[CHAN_W-1:0];
      REG_BYTE_ORDER: order_cfg = data[0];
      REG_ONE_DUTY:   one_cfg = data[DUTY_W-1:0];
      REG_ZERO_DUTY:  zero_cfg = data[DUTY_W-1:0];
      default: ;
    endcase
  endtask

  // upper bits carry junk, only the register width may land
  task automatic setup(logic [7:0] bright, logic order, logic [15:0] one, logic [15:0] zero);
    set_reg(REG_BRIGHTNESS, ($urandom() & 32'hFFFF_FF00) | 32'(bright));
    set_reg(REG_BYTE_ORDER, ($urandom() & 32'hFFFF_FFFE) | 32'(order));
    set_reg(REG_ONE_DUTY, ($urandom() & 32'hFFFF_0000) | 32'(one));
    set_reg(REG_ZERO_DUTY, ($urandom() & 32'hFFFF_0000) | 32'(zero));
    @(negedge clk);
  endtask

  task automatic drain();
    while (lamp_q.size() != 0 || in_tvalid || slot_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic queue_lamp(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    lamp_req_t q;
    q.cmd = cmd;
    q.rgb = {b, g, r};
    lamp_q.push_back(q);
  endtask

  function automatic logic [7:0] rand_level();
    case ($urandom_range(6))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] rand_duty();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset register values
    queue_lamp(CMD_LAMP, 8'hFF, 8'h81, 8'h3C);
    queue_lamp(CMD_EOF, 8'h00, 8'h00, 8'h00);
    drain();

    setup(8'd255, ORDER_GRB, 16'hFFFF, 16'h0000);
    queue_lamp(CMD_LAMP, 8'h00, 8'h00, 8'h00);
    queue_lamp(CMD_LAMP, 8'hFF, 8'hFF, 8'hFF);
    queue_lamp(CMD_LAMP, 8'hFF, 8'h00, 8'h00);
    queue_lamp(CMD_LAMP, 8'h00, 8'hFF, 8'h00);
    queue_lamp(CMD_LAMP, 8'h00, 8'h00, 8'hFF);
    queue_lamp(CMD_LAMP, 8'hA5, 8'h5A, 8'h3C);
    queue_lamp(CMD_LAMP, 8'h80, 8'h01, 8'h7F);
    queue_lamp(CMD_EOF, 8'h00, 8'h00, 8'h00);
    queue_lamp(CMD_EOF, 8'hFF, 8'hFF, 8'hFF);
    queue_lamp(CMD_LAMP, 8'h12, 8'h34, 8'h56);
    queue_lamp(CMD_EOF, 8'hC3, 8'h00, 8'h7E);
    drain();

    setup(8'd0, ORDER_RGB, 16'h0001, 16'hFFFE);
    queue_lamp(CMD_LAMP, 8'hFF, 8'hFF, 8'hFF);
    queue_lamp(CMD_LAMP, 8'h12, 8'h34, 8'h56);
    queue_lamp(CMD_EOF, 8'h00, 8'h00, 8'h00);
    drain();

    setup(8'd1, ORDER_RGB, 16'h8000, 16'h7FFF);
    queue_lamp(CMD_LAMP, 8'hFF, 8'hFE, 8'h80);
    queue_lamp(CMD_LAMP, 8'hA5, 8'h5A, 8'hFF);
    drain();

    setup(8'd254, ORDER_GRB, 16'h5555, 16'hAAAA);
    queue_lamp(CMD_LAMP, 8'hFF, 8'h80, 8'h01);
    queue_lamp(CMD_LAMP, 8'h7F, 8'hFE, 8'h02);
    drain();

    // random phases, the second one without gaps on either side
    for (int p = 0; p < 6; p++) begin
      steady = (p == 1);
      setup(($urandom_range(3) == 0) ? 8'd255 : rand_level(), 1'($urandom_range(1)),
            rand_duty(), rand_duty());
      for (int i = 0; i < 56; i++)
        queue_lamp(($urandom_range(9) == 0) ? CMD_EOF : CMD_LAMP,
                   rand_level(), rand_level(), rand_level());
      drain();
    end
    steady = 0;

    repeat (30) @(posedge clk);
    if (slot_q.size() != 0) flag_mismatch("expected slots left over");
    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout waiting for the slot stream");
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* sim.f */
hdl/rlpe_pkg.sv
hdl/rlpe_cell.sv
hdl/rlpe_loader.sv
hdl/rgb_led_pwm_slot_encoder.sv
tb/rgb_led_pwm_slot_encoder_tb.sv
